FILE: hw/rtl/ctp_pkg.sv
// ctp_pkg: shared types and constants for the cycle-time profiler.
// No dependencies; used by cycle_time_profiler, ctp_checker and the testbench.
`default_nettype none

package ctp_pkg;

    // command codes carried in s_tuser
    typedef enum logic [2:0] {
        CMD_BEGIN     = 3'd0,
        CMD_END       = 3'd1,
        CMD_QUERY     = 3'd2,
        CMD_RESET_ONE = 3'd3,
        CMD_RESET_ALL = 3'd4
    } cmd_t;

    localparam int CMD_W     = 3;
    localparam int SLOT_IN_W = 4;
    localparam int TS_W      = 64;
    localparam int TIME_W    = 32;
    localparam int COUNT_W   = 5;

    // input tdata: task_slot, timestamp, padded to whole bytes
    localparam int TS_LSB     = SLOT_IN_W;
    localparam int IN_BITS    = SLOT_IN_W + TS_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;

    // output tdata: min_time, max_time, avg_time, active_tasks, padded
    localparam int MIN_LSB     = 0;
    localparam int MAX_LSB     = TIME_W;
    localparam int AVG_LSB     = 2 * TIME_W;
    localparam int CNT_LSB     = 3 * TIME_W;
    localparam int OUT_BITS    = 3 * TIME_W + COUNT_W;
    localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

    // one entry of the statistics memory
    typedef struct packed {
        logic [TIME_W-1:0] avg;
        logic [TIME_W-1:0] max;
        logic [TIME_W-1:0] min;
    } stats_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cycle_time_profiler.sv
// cycle_time_profiler: per-slot min / max / moving-average elapsed-time monitor.
// Depends on ctp_pkg (command codes, field layout, stats entry type).
//
//  channel  dir  tdata                                   tuser
//  -------  ---  --------------------------------------  ------------
//  s_*      in   task_slot[3:0], timestamp[67:4]         command[2:0]
//  m_*      out  min[31:0] max[63:32] avg[95:64]         stats_valid
//                active_tasks[100:96]
//
// Flow: the accept cycle launches the read of the slot's entries in the two
// memories (start time, statistics) into registered read data; once the
// output register is free, the beat modifies and writes them back and loads
// the output register. s_tready stays low from accept until that write-back,
// so no read can meet a pending write to the same entry.
// Stalls: while m_tready is low with a result held, the next beat may still
// be accepted and read; its write-back waits until the output register frees.
// Reset: rst_n clears the per-slot active/begun/sample flags, the active
// count and the control state at once. The memories are not cleared: an
// entry is only used once its flag shows it was written, so there is no
// clearing pass.
`default_nettype none

module cycle_time_profiler #(
    parameter int TASK_SLOTS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // slave side
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ctp_pkg::IN_DATA_W-1:0]   s_tdata,   // task_slot, timestamp
    input  logic [ctp_pkg::CMD_W-1:0]       s_tuser,   // command
    // master side
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ctp_pkg::OUT_DATA_W-1:0]  m_tdata,   // min, max, avg, active_tasks
    output logic [0:0]                      m_tuser    // stats_valid
);
    import ctp_pkg::*;

    localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam logic [8:0] SLOT_LIMIT = 9'(TASK_SLOTS);

    // input decode
    cmd_t               in_cmd;
    logic [8:0]         in_slot_ext;
    logic [SLOT_W-1:0]  in_idx;
    logic               in_range;
    logic [TIME_W-1:0]  in_ts;
    logic               accept;

    // item under work
    logic               busy_reg;
    cmd_t               cmd_reg;
    logic               in_range_reg;
    logic [SLOT_W-1:0]  idx_reg;
    logic [TIME_W-1:0]  ts_reg;

    // memories and their registered read data
    stats_t             stats_mem [TASK_SLOTS];
    logic [TIME_W-1:0]  start_mem [TASK_SLOTS];
    stats_t             stats_rd_reg;
    logic [TIME_W-1:0]  start_rd_reg;

    // per-slot flags and active count
    logic [TASK_SLOTS-1:0] active_reg, active_next;
    logic [TASK_SLOTS-1:0] begun_reg,  begun_next;
    logic [TASK_SLOTS-1:0] sample_reg, sample_next;
    logic [COUNT_W-1:0]    total_reg,  total_next;

    // output register
    logic               m_valid_reg;
    logic               out_sv_reg;
    stats_t             out_stats_reg;
    logic [COUNT_W-1:0] out_cnt_reg;

    // update datapath
    logic               finish;
    logic               slot_act, slot_beg, slot_smp;
    logic [TIME_W-1:0]  elapsed;
    logic [TIME_W+2:0]  avg_sum;
    stats_t             stats_wdata;
    logic               stats_we, start_we, query_hit;

    assign in_cmd      = cmd_t'(s_tuser);
    assign in_slot_ext = 9'(s_tdata[SLOT_IN_W-1:0]);
    assign in_idx      = in_slot_ext[SLOT_W-1:0];
    assign in_range    = (in_slot_ext < SLOT_LIMIT);
    assign in_ts       = s_tdata[TS_LSB +: TIME_W];

    // one beat in flight; its read completes in the accept cycle
    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;
    assign finish   = busy_reg && (!m_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (accept)
        begin
            busy_reg <= 1'b1;
        end
        else if (finish)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= in_cmd;
            in_range_reg <= in_range;
            idx_reg      <= in_idx;
            ts_reg       <= in_ts;
        end
    end

    // memories: read on accept, write back when the beat finishes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stats_rd_reg <= stats_mem[in_idx];
            start_rd_reg <= start_mem[in_idx];
        end
        if (stats_we)
        begin
            stats_mem[idx_reg] <= stats_wdata;
        end
        if (start_we)
        begin
            start_mem[idx_reg] <= ts_reg;
        end
    end

    assign slot_act = active_reg[idx_reg];
    assign slot_beg = begun_reg[idx_reg];
    assign slot_smp = sample_reg[idx_reg];

    // elapsed is mod 2^32, so only the low timestamp word matters
    assign elapsed = ts_reg - start_rd_reg;

    // 7*avg + elapsed = 8*avg - avg + elapsed, never wraps in 35 bits
    assign avg_sum = {stats_rd_reg.avg, 3'b000} - {3'b000, stats_rd_reg.avg}
                   + {3'b000, elapsed};

    // a cleared entry's stored values are never seen: the first sample
    // replaces all three
    always_comb
    begin
        if (!slot_smp)
        begin
            stats_wdata.min = elapsed;
            stats_wdata.max = elapsed;
            stats_wdata.avg = elapsed;
        end
        else
        begin
            stats_wdata.min = (elapsed < stats_rd_reg.min) ? elapsed : stats_rd_reg.min;
            stats_wdata.max = (elapsed > stats_rd_reg.max) ? elapsed : stats_rd_reg.max;
            stats_wdata.avg = avg_sum[TIME_W+2:3];
        end
    end

    always_comb
    begin
        active_next = active_reg;
        begun_next  = begun_reg;
        sample_next = sample_reg;
        total_next  = total_reg;
        stats_we    = 1'b0;
        start_we    = 1'b0;
        query_hit   = 1'b0;
        if (finish)
        begin
            case (cmd_reg)
                CMD_BEGIN:
                begin
                    if (in_range_reg)
                    begin
                        if (!slot_act)
                        begin
                            active_next[idx_reg] = 1'b1;
                            sample_next[idx_reg] = 1'b0;
                            total_next           = total_reg + 1'b1;
                        end
                        begun_next[idx_reg] = 1'b1;
                        start_we            = 1'b1;
                    end
                end
                CMD_END:
                begin
                    if (in_range_reg && slot_act && slot_beg)
                    begin
                        stats_we             = 1'b1;
                        sample_next[idx_reg] = 1'b1;
                    end
                end
                CMD_QUERY:
                begin
                    query_hit = in_range_reg && slot_act && slot_smp;
                end
                CMD_RESET_ONE:
                begin
                    if (in_range_reg && slot_act)
                    begin
                        sample_next[idx_reg] = 1'b0;
                    end
                end
                CMD_RESET_ALL:
                begin
                    // only active slots ever hold a sample
                    sample_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            begun_reg  <= '0;
            sample_reg <= '0;
            total_reg  <= '0;
        end
        else
        begin
            active_reg <= active_next;
            begun_reg  <= begun_next;
            sample_reg <= sample_next;
            total_reg  <= total_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_sv_reg    <= query_hit;
            out_stats_reg <= query_hit ? stats_rd_reg : '0;
            out_cnt_reg   <= total_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_sv_reg;
    assign m_tdata  = OUT_DATA_W'({out_cnt_reg, out_stats_reg.avg,
                                   out_stats_reg.max, out_stats_reg.min});

endmodule

`default_nettype wire

FILE: hw/rtl/ctp_checker.sv
// ctp_checker: port-level assertions for cycle_time_profiler, bound below.
// Depends on ctp_pkg for the field layout.
`default_nettype none

module ctp_checker #(
    parameter int TASK_SLOTS = 16
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [ctp_pkg::IN_DATA_W-1:0]   s_tdata,
    input logic [ctp_pkg::CMD_W-1:0]       s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ctp_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic [0:0]                      m_tuser
);
    import ctp_pkg::*;

    logic [TIME_W-1:0]  f_min, f_max, f_avg;
    logic [COUNT_W-1:0] f_cnt;

    assign f_min = m_tdata[MIN_LSB +: TIME_W];
    assign f_max = m_tdata[MAX_LSB +: TIME_W];
    assign f_avg = m_tdata[AVG_LSB +: TIME_W];
    assign f_cnt = m_tdata[CNT_LSB +: COUNT_W];

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one beat in work at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("beat accepted while previous one still in work");

    // statistics are zero unless flagged valid
    a_zero_stats: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> f_min == '0 && f_max == '0 && f_avg == '0)
        else $error("statistics nonzero without stats_valid");

    // the average stays between minimum and maximum
    a_avg_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> f_min <= f_avg && f_avg <= f_max)
        else $error("average outside min/max");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (TASK_SLOTS > 31) || (int'(f_cnt) <= TASK_SLOTS))
        else $error("active count above slot count");

endmodule

bind cycle_time_profiler ctp_checker #(.TASK_SLOTS(TASK_SLOTS)) u_ctp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: dv/testbench.sv
// testbench: self-checking bench for cycle_time_profiler (per-slot elapsed-time statistics).
// Uses ctp_pkg for command codes and the beat layout.
// A queue-fed driver and a clocked monitor are scored against an in-bench profile predictor.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ctp_pkg::*;

    localparam int NUM_SLOTS     = 16;    // a 4-bit slot field reaches every slot
    localparam int RANDOM_ITEMS  = 600;
    localparam int IDLE_LIMIT    = 1500;  // cycles with no beat on either side
    localparam int HOLD_AT_CYCLE = 600;   // receiver cycle that starts the long hold-off
    localparam int HOLD_CYCLES   = 90;
    localparam int DRAIN_CYCLES  = 8;

    // codes 5..7 are not decoded by the block
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    typedef struct {
        logic [CMD_W-1:0]     command;
        logic [SLOT_IN_W-1:0] slot;
        logic [TS_W-1:0]      stamp;
    } profile_cmd_t;

    typedef struct {
        logic                valid;
        logic [TIME_W-1:0]   min_t;
        logic [TIME_W-1:0]   max_t;
        logic [TIME_W-1:0]   avg_t;
        logic [COUNT_W-1:0]  active;
    } profile_stats_t;

    // ------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #10 clk = ~clk;

    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata  = '0;   // task_slot[3:0], timestamp[67:4], zero pad
    logic [CMD_W-1:0]       s_tuser  = '0;   // command[2:0]
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;         // min[31:0], max[63:32], avg[95:64], active[100:96]
    logic [0:0]             m_tuser;         // stats_valid

    cycle_time_profiler #(
        .TASK_SLOTS (NUM_SLOTS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the per-slot table
    // ------------------------------------------------------------------
    logic [TS_W-1:0]    slot_t0    [NUM_SLOTS];
    logic [TIME_W-1:0]  stat_min   [NUM_SLOTS];
    logic [TIME_W-1:0]  stat_max   [NUM_SLOTS];
    logic [TIME_W-1:0]  stat_avg   [NUM_SLOTS];
    logic               stat_seen  [NUM_SLOTS];
    logic               slot_live  [NUM_SLOTS];
    logic               slot_armed [NUM_SLOTS];
    logic [COUNT_W-1:0] live_count;

    profile_cmd_t   cmd_backlog[$];    // beats waiting for the driver
    profile_stats_t pending_stats[$];  // results owed by the block, oldest first
    profile_cmd_t   on_bus;            // beat currently offered on s_*

    int n_items    = 0;
    int beats_in   = 0;
    int mismatches = 0;

    // stimulus bookkeeping only: last begin stamp per slot, so ends land near it
    logic [TS_W-1:0] launch_stamp [NUM_SLOTS];
    logic [TS_W-1:0] wall_clock;

    initial begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_t0[i]    = '0;
            stat_min[i]   = '1;
            stat_max[i]   = '0;
            stat_avg[i]   = '0;
            stat_seen[i]  = 1'b0;
            slot_live[i]  = 1'b0;
            slot_armed[i] = 1'b0;
        end
        live_count = '0;
    end

    function automatic void wipe_stats(input int idx);
        stat_min[idx]  = '1;
        stat_max[idx]  = '0;
        stat_avg[idx]  = '0;
        stat_seen[idx] = 1'b0;
    endfunction

    // Applies one command to the table and returns the result beat it causes.
    function automatic profile_stats_t apply_command(input profile_cmd_t c);
        profile_stats_t r;
        logic [TIME_W-1:0] el;
        logic [TIME_W+2:0] blend;   // 7*avg + el never exceeds 35 bits
        int idx;
        r = '{valid: 1'b0, min_t: '0, max_t: '0, avg_t: '0, active: '0};
        idx = int'(c.slot);
        case (c.command)
            CMD_BEGIN: begin
                // first use of a slot clears it; a re-begin only moves the start
                if (!slot_live[idx]) begin
                    wipe_stats(idx);
                    slot_live[idx] = 1'b1;
                    live_count = live_count + 1'b1;
                end
                slot_t0[idx]    = c.stamp;
                slot_armed[idx] = 1'b1;
            end
            CMD_END: begin
                // ignored unless begun; begun stays set so repeated ends share a start
                if (slot_live[idx] && slot_armed[idx]) begin
                    el = TIME_W'(c.stamp - slot_t0[idx]);
                    if (el < stat_min[idx]) stat_min[idx] = el;
                    if (el > stat_max[idx]) stat_max[idx] = el;
                    if (!stat_seen[idx]) begin
                        stat_avg[idx] = el;
                    end else begin
                        blend = (TIME_W+3)'(stat_avg[idx]) * 7 + (TIME_W+3)'(el);
                        stat_avg[idx] = blend[TIME_W+2:3];
                    end
                    stat_seen[idx] = 1'b1;
                end
            end
            CMD_QUERY: begin
                if (slot_live[idx] && stat_seen[idx]) begin
                    r.valid = 1'b1;
                    r.min_t = stat_min[idx];
                    r.max_t = stat_max[idx];
                    r.avg_t = stat_avg[idx];
                end
            end
            CMD_RESET_ONE: begin
                if (slot_live[idx]) wipe_stats(idx);
            end
            CMD_RESET_ALL: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (slot_live[i]) wipe_stats(i);
                end
            end
            default: ;  // spare codes change nothing
        endcase
        r.active = live_count;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [TS_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic queue_cmd(input logic [CMD_W-1:0] command,
                             input int slot,
                             input logic [TS_W-1:0] stamp);
        profile_cmd_t c;
        c.command = command;
        c.slot    = SLOT_IN_W'(slot);
        c.stamp   = stamp;
        cmd_backlog.push_back(c);
    endtask

    task automatic queue_begin(input int slot);
        // mostly a monotonic free-running time, sometimes anywhere in 64 bits
        wall_clock = wall_clock + $urandom_range(1, 100000);
        launch_stamp[slot] = ($urandom_range(0, 3) == 0) ? rand64() : wall_clock;
        queue_cmd(CMD_BEGIN, slot, launch_stamp[slot]);
    endtask

    task automatic queue_end(input int slot);
        logic [TS_W-1:0] stamp;
        case ($urandom_range(0, 9))
            0:       stamp = rand64();                              // anything, may wrap
            1, 2:    stamp = launch_stamp[slot] + $urandom;         // full 32-bit span
            default: stamp = launch_stamp[slot] + $urandom_range(0, 4000);
        endcase
        queue_cmd(CMD_END, slot, stamp);
    endtask

    function automatic int pick_slot();
        // favor a few slots so their statistics build up
        return ($urandom_range(0, 1) == 1) ? $urandom_range(0, 3) : $urandom_range(0, NUM_SLOTS - 1);
    endfunction

    // stray traffic between and inside well-formed begin/end episodes
    task automatic queue_noise();
        case ($urandom_range(0, 19))
            0:           queue_cmd(CMD_RESET_ALL, $urandom_range(0, NUM_SLOTS - 1), rand64());
            1, 2:        queue_cmd(CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO)),
                                   $urandom_range(0, NUM_SLOTS - 1), rand64());
            3, 4, 5:     queue_cmd(CMD_RESET_ONE, pick_slot(), rand64());
            6, 7, 8, 9:  queue_end(pick_slot());
            10, 11, 12:  queue_begin(pick_slot());
            default:     queue_cmd(CMD_QUERY, pick_slot(), rand64());
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of random length separated by random gaps
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n) begin : drive
        profile_cmd_t nxt;
        if (!rst_n) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                pending_stats.push_back(apply_command(on_bus));
                beats_in++;
            end
            // a held beat stays put until accepted; otherwise the bus is free
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (cmd_backlog.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else begin
                    nxt     = cmd_backlog.pop_front();
                    on_bus  = nxt;
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(IN_DATA_W - IN_BITS){1'b0}}, nxt.stamp, nxt.slot};
                    s_tuser  <= nxt.command;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        // a quarter of bursts run straight into the next one
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: segments of steady, patchy or mostly stalled ready,
    // plus one long hold-off that backs the block up into its input
    // ------------------------------------------------------------------
    int rx_cycle  = 0;
    int rx_mode   = 0;
    int seg_left  = 0;
    int hold_left = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready  <= 1'b0;
            rx_cycle  = 0;
            seg_left  = 0;
            hold_left = 0;
        end else begin
            rx_cycle++;
            if (rx_cycle == HOLD_AT_CYCLE) hold_left = HOLD_CYCLES;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    rx_mode  = $urandom_range(0, 3);
                    seg_left = $urandom_range(4, 40);
                end
                seg_left--;
                case (rx_mode)
                    2:       m_tready <= ($urandom_range(0, 1) == 1);
                    3:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= 1'b1;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor and scoreboard
    // ------------------------------------------------------------------
    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin : monitor
        profile_stats_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_stats.size() == 0) begin
                $error("result beat with no command outstanding: tdata 0x%0h", m_tdata);
                mismatches++;
            end else begin
                want = pending_stats.pop_front();
                check_field("stats_valid", 32'(want.valid), 32'(m_tuser[0]));
                check_field("min_time", want.min_t, m_tdata[MIN_LSB +: TIME_W]);
                check_field("max_time", want.max_t, m_tdata[MAX_LSB +: TIME_W]);
                check_field("avg_time", want.avg_t, m_tdata[AVG_LSB +: TIME_W]);
                check_field("active_tasks", 32'(want.active), 32'(m_tdata[CNT_LSB +: COUNT_W]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any beat on either side ends the run
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin : stimulus
        int slot;
        wall_clock = rand64();
        for (int i = 0; i < NUM_SLOTS; i++) launch_stamp[i] = wall_clock;

        // directed: untouched slot, end before begin, reset of an inactive slot
        queue_cmd(CMD_QUERY, 0, '0);
        queue_cmd(CMD_END, 0, '1);
        queue_cmd(CMD_RESET_ONE, 0, '0);
        // largest elapsed, twice: the average must not overflow
        queue_cmd(CMD_BEGIN, 0, '0);
        queue_cmd(CMD_END, 0, 64'h0000_0000_FFFF_FFFF);
        queue_cmd(CMD_END, 0, '1);
        queue_cmd(CMD_QUERY, 0, '0);
        // timestamp wraps past 2^64, then a zero elapsed on the last slot
        queue_cmd(CMD_BEGIN, 15, 64'hFFFF_FFFF_FFFF_FFF0);
        queue_cmd(CMD_END, 15, 64'h0000_0000_0000_0005);
        queue_cmd(CMD_END, 15, 64'hFFFF_FFFF_FFFF_FFF0);
        queue_cmd(CMD_QUERY, 15, '1);
        // begin on an active slot keeps its statistics
        queue_cmd(CMD_BEGIN, 0, 64'd100);
        queue_cmd(CMD_END, 0, 64'd103);
        queue_cmd(CMD_QUERY, 0, '0);
        // single-slot reset keeps the start time
        queue_cmd(CMD_RESET_ONE, 15, '0);
        queue_cmd(CMD_QUERY, 15, '0);
        queue_cmd(CMD_END, 15, 64'h0000_0001_0000_0010);
        queue_cmd(CMD_QUERY, 15, '0);
        queue_cmd(CMD_BEGIN, 7, 64'hA5A5_5A5A_0F0F_F0F0);
        queue_cmd(CMD_RESET_ALL, 9, '0);
        queue_cmd(CMD_QUERY, 0, '0);
        queue_cmd(CMD_QUERY, 15, '0);
        // spare codes do nothing
        queue_cmd(CMD_SPARE_LO, 0, '1);
        queue_cmd(CMD_SPARE_LO + 3'd1, 15, '0);
        queue_cmd(CMD_SPARE_HI, 7, '1);
        queue_cmd(CMD_QUERY, 7, '0);

        // random: mostly begin / end episodes, noise woven in
        n_items = cmd_backlog.size() + RANDOM_ITEMS;
        while (cmd_backlog.size() < n_items) begin
            if ($urandom_range(0, 9) < 7) begin
                slot = pick_slot();
                queue_begin(slot);
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(0, 3) == 0) queue_noise();
                    queue_end(slot);
                end
                if ($urandom_range(0, 4) != 0) queue_cmd(CMD_QUERY, slot, rand64());
            end else begin
                queue_noise();
            end
        end
        n_items = cmd_backlog.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (beats_in < n_items || pending_stats.size() != 0) @(posedge clk);
        // catch any stray beat the block might still emit
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_stats.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
